FILE: rtl/dps_pkg.sv
// Package for the dashed polyline stroker: payload structs, widths and
// register indexes. No dependencies.
package dps_pkg;

  localparam int COORD_BITS = 11;
  localparam int LEN_BITS = 16;
  localparam int DEF_FRAC_BITS = 4;
  localparam int DEF_MAX_POINTS = 64;
  localparam logic [LEN_BITS-1:0] STROKE_RESET = 16'd230;
  localparam logic [LEN_BITS-1:0] GAP_RESET = 16'd115;

  localparam logic REG_STROKE_LENGTH = 1'b0;
  localparam logic REG_GAP_LENGTH = 1'b1;

  typedef struct packed {
    logic [COORD_BITS-1:0] vertex_x;
    logic [COORD_BITS-1:0] vertex_y;
    logic                  contour_first;
    logic                  contour_last;
  } vertex_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic                  stroke_begin;
    logic                  stroke_end;
    logic                  overflow;
    logic                  last_of_item;
  } point_t;

endpackage

FILE: rtl/dashed_polyline_stroker.sv
// Dashed polyline stroker top level: sequencer around one shared multiplier
// and separate subtract/compare logic for square root and division. Uses dps_pkg.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  vertex_t
//   out_     output     out_valid/out_stall  point_t
//   cfg_     input      cfg_we               cfg_addr, cfg_wdata
//
// A contour-start vertex emits its point with no arithmetic. A segment length squares dx
// and dy, sums them and takes the root (one root bit a cycle); each dash cut adds
// a multiply and restoring division per coordinate (none when the cut falls on
// the pen), a step to move the pen and a new segment length. Each point waits
// in a pending register while out_stall holds; a last step closes the vertex.
// in_stall is high from acceptance until the last point sits in the output
// register. Reset is synchronous, active low; out_stall only holds points back.
module dashed_polyline_stroker
  import dps_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  parameter int MAX_POINTS_PER_VERTEX = DEF_MAX_POINTS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  vertex_t             in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output point_t              out_data,
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [LEN_BITS-1:0] cfg_wdata
);

  localparam int CB = COORD_BITS;
  localparam int LEN_W = CB + FRAC_BITS + 1;
  localparam int RAD_W = 2 * LEN_W;
  localparam int PROD_W = CB + LEN_W;
  localparam int NUM_W = PROD_W + 1;
  localparam int SUM_W = ((LEN_W > LEN_BITS) ? LEN_W : LEN_BITS) + 1;
  localparam int IT_W = $clog2(LEN_W + 1);
  localparam int CNT_W = $clog2(MAX_POINTS_PER_VERTEX + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQX   = 4'd1;
  localparam logic [3:0] S_SQY   = 4'd2;
  localparam logic [3:0] S_SQA   = 4'd3;
  localparam logic [3:0] S_SQRT  = 4'd4;
  localparam logic [3:0] S_CMP   = 4'd5;
  localparam logic [3:0] S_M0    = 4'd6;
  localparam logic [3:0] S_M1    = 4'd7;
  localparam logic [3:0] S_M2    = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_APPLY = 4'd10;
  localparam logic [3:0] S_EMIT  = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  logic [3:0]          state_r, ret_r;
  logic [LEN_BITS-1:0] stroke_len_r, gap_len_r, phase_r, need_r;
  logic [CB-1:0]       pen_x_r, pen_y_r, vx_r, vy_r, qx_r, q_r, lo_r;
  logic                last_r, in_gap_r, active_r, open_r, ovf_r, axis_r;
  logic [LEN_W-1:0]    len_r, root_r;
  logic [LEN_W:0]      rem_r;
  logic [RAD_W-1:0]    rad_r;
  logic [PROD_W-1:0]   prod_r;
  logic [NUM_W-1:0]    num_r;
  logic [IT_W-1:0]     it_r;
  logic [CNT_W-1:0]    cnt_r;
  point_t              em_r, pend_r, out_r;
  logic                pend_v_r, out_v_r;

  logic [CB-1:0]       dx, dy, mul_a, pos_p, pos_v;
  logic [LEN_W-1:0]    mul_b;
  logic [PROD_W-1:0]   mul_p;
  logic [LEN_W+2:0]    sq_rem2, sq_trial;
  logic [LEN_W+1:0]    dv_rem2;
  logic [SUM_W-1:0]    ph_sum;
  logic [LEN_BITS-1:0] limit;
  logic [NUM_W-1:0]    num_sum;
  logic                out_free, in_acc, out_load;
  point_t              fin_pt;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign out_valid = out_v_r;
  assign out_data = out_r;
  assign out_free = !out_v_r || !out_stall;

  assign dx = (pen_x_r > vx_r) ? pen_x_r - vx_r : vx_r - pen_x_r;
  assign dy = (pen_y_r > vy_r) ? pen_y_r - vy_r : vy_r - pen_y_r;
  assign pos_p = axis_r ? pen_y_r : pen_x_r;
  assign pos_v = axis_r ? vy_r : vx_r;
  assign limit = in_gap_r ? gap_len_r : stroke_len_r;
  assign ph_sum = SUM_W'(phase_r) + SUM_W'(root_r);
  assign num_sum = num_r + NUM_W'(prod_r);

  assign out_load = pend_v_r && out_free &&
                    ((state_r == S_EMIT && cnt_r != CNT_W'(MAX_POINTS_PER_VERTEX)) ||
                     state_r == S_FIN);
  assign fin_pt = '{pend_r.point_x, pend_r.point_y, pend_r.stroke_begin,
                    pend_r.stroke_end || (last_r && !ovf_r && open_r), ovf_r, 1'b1};

  always_comb begin
    unique case (state_r)
      S_SQX: begin
        mul_a = dx;
        mul_b = LEN_W'(dx);
      end
      S_SQY: begin
        mul_a = dy;
        mul_b = LEN_W'(dy);
      end
      S_M0: begin
        mul_a = pos_p;
        mul_b = len_r - LEN_W'(need_r);
      end
      default: begin
        mul_a = pos_v;
        mul_b = LEN_W'(need_r);
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign sq_rem2 = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign sq_trial = {1'b0, root_r, 2'b01};
  assign dv_rem2 = {rem_r, lo_r[CB-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      stroke_len_r <= STROKE_RESET;
      gap_len_r <= GAP_RESET;
      pen_x_r <= '0;
      pen_y_r <= '0;
      phase_r <= '0;
      in_gap_r <= 1'b0;
      active_r <= 1'b0;
      open_r <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r <= 1'b0;
      ovf_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (out_load) begin
        out_r <= (state_r == S_FIN) ? fin_pt : pend_r;
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_STROKE_LENGTH: stroke_len_r <= cfg_wdata;
          REG_GAP_LENGTH: gap_len_r <= cfg_wdata;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            vx_r <= in_data.vertex_x;
            vy_r <= in_data.vertex_y;
            last_r <= in_data.contour_last;
            cnt_r <= '0;
            ovf_r <= 1'b0;
            pend_v_r <= 1'b0;
            if (in_data.contour_first || !active_r) begin
              pen_x_r <= in_data.vertex_x;
              pen_y_r <= in_data.vertex_y;
              in_gap_r <= 1'b0;
              phase_r <= '0;
              active_r <= 1'b1;
              open_r <= 1'b1;
              em_r <= '{in_data.vertex_x, in_data.vertex_y, 1'b1, 1'b0, 1'b0, 1'b0};
              ret_r <= S_FIN;
              state_r <= S_EMIT;
            end else begin
              state_r <= S_SQX;
            end
          end
        end
        S_SQX: begin
          prod_r <= mul_p;
          state_r <= S_SQY;
        end
        S_SQY: begin
          rad_r <= RAD_W'(prod_r);
          prod_r <= mul_p;
          state_r <= S_SQA;
        end
        S_SQA: begin
          rad_r <= (rad_r + RAD_W'(prod_r)) << (2 * FRAC_BITS);
          rem_r <= '0;
          root_r <= '0;
          it_r <= IT_W'(LEN_W);
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_rem2 >= sq_trial) begin
            rem_r <= (LEN_W+1)'(sq_rem2 - sq_trial);
            root_r <= {root_r[LEN_W-2:0], 1'b1};
          end else begin
            rem_r <= (LEN_W+1)'(sq_rem2);
            root_r <= {root_r[LEN_W-2:0], 1'b0};
          end
          rad_r <= rad_r << 2;
          it_r <= it_r - 1'b1;
          if (it_r == IT_W'(1)) begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          len_r <= root_r;
          if (ph_sum <= SUM_W'(limit)) begin
            phase_r <= LEN_BITS'(ph_sum);
            if (!in_gap_r) begin
              em_r <= '{vx_r, vy_r, 1'b0, 1'b0, 1'b0, 1'b0};
              ret_r <= S_FIN;
              state_r <= S_EMIT;
            end else begin
              state_r <= S_FIN;
            end
          end else begin
            need_r <= (phase_r > limit) ? '0 : limit - phase_r;
            axis_r <= 1'b0;
            if (phase_r >= limit) begin
              qx_r <= pen_x_r;
              q_r <= pen_y_r;
              state_r <= S_APPLY;
            end else begin
              state_r <= S_M0;
            end
          end
        end
        S_M0: begin
          prod_r <= mul_p;
          state_r <= S_M1;
        end
        S_M1: begin
          num_r <= NUM_W'(prod_r);
          prod_r <= mul_p;
          state_r <= S_M2;
        end
        S_M2: begin
          rem_r <= num_sum[NUM_W-1:CB];
          lo_r <= num_sum[CB-1:0];
          it_r <= IT_W'(CB);
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (dv_rem2 >= (LEN_W+2)'(len_r)) begin
            rem_r <= (LEN_W+1)'(dv_rem2 - (LEN_W+2)'(len_r));
            q_r <= {q_r[CB-2:0], 1'b1};
          end else begin
            rem_r <= (LEN_W+1)'(dv_rem2);
            q_r <= {q_r[CB-2:0], 1'b0};
          end
          lo_r <= lo_r << 1;
          it_r <= it_r - 1'b1;
          if (it_r == IT_W'(1)) begin
            if (!axis_r) begin
              axis_r <= 1'b1;
              state_r <= S_M0;
            end else begin
              state_r <= S_APPLY;
            end
          end
          if (it_r == IT_W'(1) && !axis_r) begin
            qx_r <= {q_r[CB-2:0], (dv_rem2 >= (LEN_W+2)'(len_r))};
          end
        end
        S_APPLY: begin
          pen_x_r <= qx_r;
          pen_y_r <= q_r;
          phase_r <= '0;
          in_gap_r <= !in_gap_r;
          open_r <= in_gap_r;
          em_r <= '{qx_r, q_r, in_gap_r, !in_gap_r, 1'b0, 1'b0};
          ret_r <= S_SQX;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (cnt_r == CNT_W'(MAX_POINTS_PER_VERTEX)) begin
            ovf_r <= 1'b1;
            state_r <= S_FIN;
          end else if (!pend_v_r || out_free) begin
            pend_r <= em_r;
            pend_v_r <= 1'b1;
            cnt_r <= cnt_r + 1'b1;
            state_r <= ret_r;
          end
        end
        S_FIN: begin
          if (!pend_v_r || out_free) begin
            pend_v_r <= 1'b0;
            pen_x_r <= vx_r;
            pen_y_r <= vy_r;
            if (last_r) begin
              open_r <= 1'b0;
              active_r <= 1'b0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
